// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_UNTERMINATED = 3'd0,
    ERR_INCOMPLETE   = 3'd1,
    ERR_INVALID_ESC  = 3'd2,
    ERR_MISSING_HEX  = 3'd3,
    ERR_BAD_HEX      = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    MODE_TEXT        = 3'd0,
    MODE_ESC         = 3'd1,
    MODE_HEX1        = 3'd2,
    MODE_HEX1_BAD    = 3'd3,
    MODE_AFTER_HI    = 3'd4,
    MODE_AFTER_HI_BS = 3'd5,
    MODE_HEX2        = 3'd6,
    MODE_HEX2_BAD    = 3'd7
  } mode_t;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CP_W        = 21;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  localparam logic [15:0]     HI_SURR_MIN  = 16'hD800;
  localparam logic [15:0]     HI_SURR_MAX  = 16'hDBFF;
  localparam logic [15:0]     LO_SURR_BASE = 16'hDC00;
  localparam logic [CP_W-1:0] SUPP_BASE    = 21'h10000;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       code;
  } res_t;

  typedef struct packed {
    logic [2:0]       cnt;
    res_t [3:0]       r;
  } bundle_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  b;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
    utf8_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  function automatic hexd_t hex_value(input logic [7:0] c);
    hexd_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

// ----- rtl/jsu_decode.sv -----
module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       in_byte,
  input  logic             text_end,
  output jsu_pkg::bundle_t bundle
);

  jsu_pkg::mode_t mode, mode_next;
  logic [1:0]     hcnt, hcnt_next;
  logic [15:0]    acc, acc_next;
  logic [15:0]    hi, hi_next;
  logic           err, err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jsu_pkg::MODE_TEXT;
      hcnt <= '0;
      acc  <= '0;
      hi   <= '0;
      err  <= 1'b0;
    end else if (go) begin
      mode <= mode_next;
      hcnt <= hcnt_next;
      acc  <= acc_next;
      hi   <= hi_next;
      err  <= err_next;
    end
  end

  always_comb begin
    logic              text_path;
    logic              esc_path;
    logic              prefix;
    logic              do_enc;
    logic              fail;
    jsu_pkg::err_t     fcode;
    logic [2:0]        n;
    jsu_pkg::res_t [3:0] r;
    jsu_pkg::utf8_t    e;
    jsu_pkg::utf8_t    ep;
    jsu_pkg::hexd_t    h;
    logic              bad;
    logic [jsu_pkg::CP_W-1:0] cp;
    logic [9:0]        hi_off;

    mode_next = mode;
    hcnt_next = hcnt;
    acc_next  = acc;
    hi_next   = hi;
    err_next  = err;
    text_path = 1'b0;
    esc_path  = 1'b0;
    prefix    = 1'b0;
    do_enc    = 1'b0;
    fail      = 1'b0;
    fcode     = jsu_pkg::ERR_UNTERMINATED;
    n         = '0;
    r         = '0;
    e         = '0;
    ep        = '0;
    h         = jsu_pkg::hex_value(in_byte);
    bad       = mode[0] | ~h.ok;
    hi_off    = 10'(hi - jsu_pkg::HI_SURR_MIN);
    cp        = '0;

    if (!err) begin
      case (mode)
        jsu_pkg::MODE_TEXT: text_path = 1'b1;
        jsu_pkg::MODE_ESC:  esc_path = 1'b1;
        jsu_pkg::MODE_AFTER_HI: begin
          if (in_byte == jsu_pkg::CH_BSLASH && !text_end) begin
            mode_next = jsu_pkg::MODE_AFTER_HI_BS;
          end else begin
            prefix    = 1'b1;
            text_path = 1'b1;
          end
        end
        jsu_pkg::MODE_AFTER_HI_BS: begin
          if (in_byte == jsu_pkg::CH_U) begin
            if (text_end) begin
              fail  = 1'b1;
              fcode = jsu_pkg::ERR_MISSING_HEX;
            end else begin
              mode_next = jsu_pkg::MODE_HEX2;
              hcnt_next = '0;
              acc_next  = '0;
            end
          end else begin
            prefix   = 1'b1;
            esc_path = 1'b1;
          end
        end
        default: begin
          // hex digit collection for either word
          acc_next = {acc[11:0], h.ok ? h.val : 4'd0};
          if (hcnt != 2'd3) begin
            if (text_end) begin
              fail  = 1'b1;
              fcode = jsu_pkg::ERR_MISSING_HEX;
            end else begin
              hcnt_next = hcnt + 2'd1;
              mode_next = jsu_pkg::mode_t'({mode[2:1], bad});
            end
          end else begin
            hcnt_next = '0;
            mode_next = jsu_pkg::MODE_TEXT;
            if (bad) begin
              fail  = 1'b1;
              fcode = jsu_pkg::ERR_BAD_HEX;
            end else if (!mode[2]) begin
              if (acc_next >= jsu_pkg::HI_SURR_MIN && acc_next <= jsu_pkg::HI_SURR_MAX) begin
                if (text_end) begin
                  fail  = 1'b1;
                  fcode = jsu_pkg::ERR_UNTERMINATED;
                end else begin
                  hi_next   = acc_next;
                  mode_next = jsu_pkg::MODE_AFTER_HI;
                end
              end else begin
                cp     = jsu_pkg::CP_W'(acc_next);
                do_enc = 1'b1;
              end
            end else begin
              cp = jsu_pkg::CP_W'({hi_off, 10'd0}) + jsu_pkg::CP_W'(acc_next)
                 + (jsu_pkg::SUPP_BASE - jsu_pkg::CP_W'(jsu_pkg::LO_SURR_BASE));
              do_enc = 1'b1;
            end
          end
        end
      endcase
    end

    // lone high surrogate goes out ahead of the byte that broke the pair
    if (prefix) begin
      ep = jsu_pkg::utf8_encode(jsu_pkg::CP_W'(hi));
      for (int i = 0; i < 3; i++) begin
        r[i] = '{kind: jsu_pkg::KIND_DATA, data: ep.b[i], code: jsu_pkg::ERR_UNTERMINATED};
      end
      n = 3'd3;
    end

    if (text_path) begin
      mode_next = jsu_pkg::MODE_TEXT;
      if (in_byte == jsu_pkg::CH_QUOTE) begin
        r[n[1:0]] = '{kind: jsu_pkg::KIND_CLOSE, data: 8'd0,
                      code: jsu_pkg::ERR_UNTERMINATED};
        n = n + 3'd1;
      end else if (in_byte == jsu_pkg::CH_BSLASH) begin
        if (text_end) begin
          fail  = 1'b1;
          fcode = jsu_pkg::ERR_INCOMPLETE;
        end else begin
          mode_next = jsu_pkg::MODE_ESC;
        end
      end else begin
        r[n[1:0]] = '{kind: jsu_pkg::KIND_DATA, data: in_byte,
                      code: jsu_pkg::ERR_UNTERMINATED};
        n = n + 3'd1;
        if (text_end) begin
          fail  = 1'b1;
          fcode = jsu_pkg::ERR_UNTERMINATED;
        end
      end
    end

    if (esc_path) begin
      mode_next = jsu_pkg::MODE_TEXT;
      case (in_byte)
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
        jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T: begin
          r[n[1:0]].kind = jsu_pkg::KIND_DATA;
          r[n[1:0]].code = jsu_pkg::ERR_UNTERMINATED;
          case (in_byte)
            jsu_pkg::CH_B: r[n[1:0]].data = jsu_pkg::CTL_BS;
            jsu_pkg::CH_F: r[n[1:0]].data = jsu_pkg::CTL_FF;
            jsu_pkg::CH_N: r[n[1:0]].data = jsu_pkg::CTL_LF;
            jsu_pkg::CH_R: r[n[1:0]].data = jsu_pkg::CTL_CR;
            jsu_pkg::CH_T: r[n[1:0]].data = jsu_pkg::CTL_TAB;
            default:       r[n[1:0]].data = in_byte;
          endcase
          n = n + 3'd1;
          if (text_end) begin
            fail  = 1'b1;
            fcode = jsu_pkg::ERR_UNTERMINATED;
          end
        end
        jsu_pkg::CH_U: begin
          if (text_end) begin
            fail  = 1'b1;
            fcode = jsu_pkg::ERR_MISSING_HEX;
          end else begin
            mode_next = jsu_pkg::MODE_HEX1;
            hcnt_next = '0;
            acc_next  = '0;
          end
        end
        default: begin
          fail  = 1'b1;
          fcode = jsu_pkg::ERR_INVALID_ESC;
        end
      endcase
    end

    if (do_enc) begin
      e = jsu_pkg::utf8_encode(cp);
      for (int i = 0; i < 4; i++) begin
        r[i] = '{kind: jsu_pkg::KIND_DATA, data: e.b[i], code: jsu_pkg::ERR_UNTERMINATED};
      end
      n = e.n;
      if (text_end) begin
        fail  = 1'b1;
        fcode = jsu_pkg::ERR_UNTERMINATED;
      end
    end

    // an error drops everything else from this byte and sticks
    if (fail) begin
      n         = 3'd1;
      r         = '0;
      r[0].kind = jsu_pkg::KIND_ERROR;
      r[0].code = fcode;
      err_next  = 1'b1;
      mode_next = jsu_pkg::MODE_TEXT;
    end

    bundle.cnt = n;
    bundle.r   = r;
  end

endmodule

// ----- rtl/jsu_emit.sv -----
module jsu_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::bundle_t bundle,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic [2:0]       error_code,
  output logic             last_of_run
);

  logic             bv;
  logic [1:0]       idx;
  jsu_pkg::bundle_t bun;
  jsu_pkg::res_t    cur;
  logic             last;

  assign cur         = bun.r[idx];
  assign last        = ({1'b0, idx} == bun.cnt - 3'd1);
  assign free        = !bv || (out_ready && last);
  assign out_valid   = bv;
  assign kind        = cur.kind;
  assign out_byte    = cur.data;
  assign error_code  = cur.code;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv  <= 1'b0;
      idx <= '0;
    end else if (load) begin
      bv  <= 1'b1;
      idx <= '0;
    end else if (bv && out_ready) begin
      if (last) begin
        bv <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun <= bundle;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    bv |-> (bun.cnt != 3'd0 && bun.cnt <= 3'd4))
    else $error("result group count out of range");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    bv |-> ({1'b0, idx} < bun.cnt))
    else $error("result index past group end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!bv || (out_ready && last)))
    else $error("result group overwritten before drained");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (bv && cur.kind == jsu_pkg::KIND_ERROR) |-> (bun.cnt == 3'd1))
    else $error("error transaction shares a group with other results");

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
// Streaming JSON string unescaper: one raw byte of string text per input
// transaction, decoded UTF-8 bytes, string-close markers and error reports
// out. A byte is held in an input register, decoded combinationally and
// its one to four results are loaded into an output group register that
// presents one result per cycle while out_ready is high; the input
// register takes the next byte while that group waits. Zero-result bytes,
// and one-result bytes while out_ready is high, run at one per cycle; an
// n-result byte holds the output until all n are taken, so the sustained
// rate is set by the output port. Errors are sticky until reset.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [2:0] error_code,
  output logic       last_of_run
);

  logic             iv;
  logic [7:0]       ib;
  logic             ie;
  logic             go;
  logic             free;
  jsu_pkg::bundle_t bundle;

  assign go       = iv && (free || bundle.cnt == 3'd0);
  assign in_ready = !iv || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv <= 1'b1;
    end else if (go) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib <= in_byte;
      ie <= text_end;
    end
  end

  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .in_byte  (ib),
    .text_end (ie),
    .bundle   (bundle)
  );

  jsu_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (go && bundle.cnt != 3'd0),
    .bundle      (bundle),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 370;

  typedef enum logic [1:0] {
    BY_MODEL   = 2'd0,
    NO_RESULT  = 2'd1,
    ONE_RESULT = 2'd2
  } row_form_t;

  typedef struct packed {
    jsu_pkg::kind_t kind;
    logic [7:0]     data;
    jsu_pkg::err_t  code;
    logic           last;
  } outcome_t;

  typedef struct packed {
    logic [7:0]     b;
    logic           fin;
    row_form_t      form;
    jsu_pkg::kind_t k;
    logic [7:0]     d;
    jsu_pkg::err_t  c;
  } row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } raw_t;

  // code field is zero (ERR_UNTERMINATED) unless an error is reported
  localparam row_t DIRECTED [25] = '{
    '{8'h00, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, 8'h00, jsu_pkg::ERR_UNTERMINATED},
    '{8'hFF, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, 8'hFF, jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_QUOTE, 1'b1, ONE_RESULT, jsu_pkg::KIND_CLOSE, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_QUOTE, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CH_QUOTE,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CH_BSLASH,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_SLASH, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CH_SLASH,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_B, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CTL_BS,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_F, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CTL_FF,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_N, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CTL_LF,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_R, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CTL_CR,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_T, 1'b0, ONE_RESULT, jsu_pkg::KIND_DATA, jsu_pkg::CTL_TAB,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_BSLASH, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{jsu_pkg::CH_U, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00,
      jsu_pkg::ERR_UNTERMINATED},
    '{8'h30, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00, jsu_pkg::ERR_UNTERMINATED},
    '{8'h30, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00, jsu_pkg::ERR_UNTERMINATED},
    '{8'h65, 1'b0, NO_RESULT, jsu_pkg::KIND_DATA, 8'h00, jsu_pkg::ERR_UNTERMINATED},
    '{8'h41, 1'b0, BY_MODEL,  jsu_pkg::KIND_DATA, 8'h00, jsu_pkg::ERR_UNTERMINATED}
  };

  localparam logic [7:0] ESC_CHARS [8] = '{
    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
    jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T
  };

  localparam logic [15:0] EDGE_WORDS [8] = '{
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD800, 16'hDBFF
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       text_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last_of_run;

  json_string_unescape_utf8 uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .text_end(text_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .out_byte(out_byte),
    .error_code(error_code),
    .last_of_run(last_of_run)
  );

  // decoder state mirror
  jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_TEXT;
  logic [1:0]  hex_seen = 2'd0;
  logic [15:0] hex_acc = 16'h0000;
  logic [15:0] hi_word = 16'h0000;
  bit          stuck = 1'b0;

  outcome_t    step_out[$];
  outcome_t    utf8_pending[$];
  raw_t        stim_q[$];

  bit          idle_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned last_err = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void put_result(jsu_pkg::kind_t k, logic [7:0] d, jsu_pkg::err_t c);
    outcome_t o;
    if (step_out.size() < jsu_pkg::MAX_RESULTS) begin
      o.kind = k;
      o.data = d;
      o.code = c;
      o.last = 1'b0;
      step_out.insert(step_out.size(), o);
    end
  endfunction

  function automatic void put_data(logic [7:0] d);
    put_result(jsu_pkg::KIND_DATA, d, jsu_pkg::ERR_UNTERMINATED);
  endfunction

  // an error drops whatever this byte produced and silences the decoder
  function automatic void go_error(jsu_pkg::err_t c);
    step_out.delete();
    put_result(jsu_pkg::KIND_ERROR, 8'h00, c);
    stuck = 1'b1;
    dec_mode = jsu_pkg::MODE_TEXT;
  endfunction

  function automatic void utf8_put(logic [31:0] cp);
    if (cp < 32'h80) begin
      put_data(cp[7:0]);
    end else if (cp < 32'h800) begin
      put_data({3'b110, cp[10:6]});
      put_data({2'b10, cp[5:0]});
    end else if (cp < 32'(jsu_pkg::SUPP_BASE)) begin
      put_data({4'b1110, cp[15:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end else begin
      put_data({5'b11110, cp[20:18]});
      put_data({2'b10, cp[17:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void text_char(logic [7:0] b, logic fin);
    dec_mode = jsu_pkg::MODE_TEXT;
    if (b == jsu_pkg::CH_QUOTE) begin
      put_result(jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_UNTERMINATED);
    end else if (b == jsu_pkg::CH_BSLASH) begin
      if (fin) go_error(jsu_pkg::ERR_INCOMPLETE);
      else dec_mode = jsu_pkg::MODE_ESC;
    end else begin
      put_data(b);
      if (fin) go_error(jsu_pkg::ERR_UNTERMINATED);
    end
  endfunction

  function automatic void escape_char(logic [7:0] b, logic fin);
    logic [7:0] v;
    bit         plain;
    dec_mode = jsu_pkg::MODE_TEXT;
    plain = 1'b1;
    v = b;
    case (b)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: v = b;
      jsu_pkg::CH_B: v = jsu_pkg::CTL_BS;
      jsu_pkg::CH_F: v = jsu_pkg::CTL_FF;
      jsu_pkg::CH_N: v = jsu_pkg::CTL_LF;
      jsu_pkg::CH_R: v = jsu_pkg::CTL_CR;
      jsu_pkg::CH_T: v = jsu_pkg::CTL_TAB;
      jsu_pkg::CH_U: begin
        plain = 1'b0;
        if (fin) begin
          go_error(jsu_pkg::ERR_MISSING_HEX);
        end else begin
          dec_mode = jsu_pkg::MODE_HEX1;
          hex_seen = 2'd0;
          hex_acc = 16'h0000;
        end
      end
      default: begin
        plain = 1'b0;
        go_error(jsu_pkg::ERR_INVALID_ESC);
      end
    endcase
    if (plain) begin
      put_data(v);
      if (fin) go_error(jsu_pkg::ERR_UNTERMINATED);
    end
  endfunction

  function automatic void hex_char(logic [7:0] b, logic fin);
    logic [4:0]  h;
    logic [2:0]  mbits;
    logic [2:0]  base;
    bit          bad;
    logic [31:0] cp;
    mbits = dec_mode;
    base = {mbits[2:1], 1'b0};
    h = hex_nibble(b);
    bad = mbits[0] || !h[4];
    hex_acc = {hex_acc[11:0], h[4] ? h[3:0] : 4'h0};
    if (hex_seen < 2'd3) begin
      if (fin) begin
        go_error(jsu_pkg::ERR_MISSING_HEX);
      end else begin
        hex_seen = hex_seen + 2'd1;
        dec_mode = jsu_pkg::mode_t'({base[2:1], bad});
      end
    end else begin
      hex_seen = 2'd0;
      if (bad) begin
        go_error(jsu_pkg::ERR_BAD_HEX);
      end else begin
        dec_mode = jsu_pkg::MODE_TEXT;
        if (base == jsu_pkg::MODE_HEX1 && hex_acc >= jsu_pkg::HI_SURR_MIN &&
            hex_acc <= jsu_pkg::HI_SURR_MAX) begin
          if (fin) begin
            go_error(jsu_pkg::ERR_UNTERMINATED);
          end else begin
            hi_word = hex_acc;
            dec_mode = jsu_pkg::MODE_AFTER_HI;
          end
        end else begin
          if (base == jsu_pkg::MODE_HEX1)
            cp = {16'h0000, hex_acc};
          else
            cp = 32'(jsu_pkg::SUPP_BASE)
                 + (({16'h0000, hi_word} - {16'h0000, jsu_pkg::HI_SURR_MIN}) << 10)
                 + ({16'h0000, hex_acc} - {16'h0000, jsu_pkg::LO_SURR_BASE});
          utf8_put(cp);
          if (fin) go_error(jsu_pkg::ERR_UNTERMINATED);
        end
      end
    end
  endfunction

  function automatic void unescape_byte(logic [7:0] b, logic fin);
    step_out.delete();
    if (!stuck) begin
      case (dec_mode)
        jsu_pkg::MODE_TEXT: text_char(b, fin);
        jsu_pkg::MODE_ESC: escape_char(b, fin);
        jsu_pkg::MODE_AFTER_HI: begin
          if (b == jsu_pkg::CH_BSLASH && !fin) begin
            dec_mode = jsu_pkg::MODE_AFTER_HI_BS;
          end else begin
            utf8_put({16'h0000, hi_word});
            text_char(b, fin);
          end
        end
        jsu_pkg::MODE_AFTER_HI_BS: begin
          if (b == jsu_pkg::CH_U) begin
            if (fin) begin
              go_error(jsu_pkg::ERR_MISSING_HEX);
            end else begin
              dec_mode = jsu_pkg::MODE_HEX2;
              hex_seen = 2'd0;
              hex_acc = 16'h0000;
            end
          end else begin
            utf8_put({16'h0000, hi_word});
            escape_char(b, fin);
          end
        end
        default: hex_char(b, fin);
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] hex_text(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] digit_or_junk(bit junk);
    logic [7:0] c;
    logic [4:0] h;
    if (!junk) return hex_text(4'($urandom_range(0, 15)));
    do begin
      c = 8'($urandom_range(0, 255));
      h = hex_nibble(c);
    end while (h[4]);
    return c;
  endfunction

  function automatic void push_raw(logic [7:0] b, logic fin);
    raw_t r;
    r.b = b;
    r.fin = fin;
    stim_q.insert(stim_q.size(), r);
  endfunction

  function automatic void push_word(logic [15:0] w, logic fin);
    push_raw(jsu_pkg::CH_BSLASH, 1'b0);
    push_raw(jsu_pkg::CH_U, 1'b0);
    push_raw(hex_text(w[15:12]), 1'b0);
    push_raw(hex_text(w[11:8]), 1'b0);
    push_raw(hex_text(w[7:4]), 1'b0);
    push_raw(hex_text(w[3:0]), fin);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(0, 16'hFFFF));
      3: return 16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX));
      default: return EDGE_WORDS[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic void add_segment();
    int unsigned r;
    logic [7:0]  b;
    logic [15:0] hi;
    r = $urandom_range(0, 99);
    hi = 16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX));
    if (r < 28) begin
      do b = 8'($urandom_range(0, 255));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      push_raw(b, 1'b0);
    end else if (r < 38) begin
      push_raw(jsu_pkg::CH_QUOTE, $urandom_range(0, 3) == 0);
    end else if (r < 54) begin
      push_raw(jsu_pkg::CH_BSLASH, 1'b0);
      push_raw(ESC_CHARS[$urandom_range(0, 7)], 1'b0);
    end else if (r < 72) begin
      push_word(pick_word(), 1'b0);
    end else if (r < 86) begin
      // well-formed surrogate pair
      push_word(hi, 1'b0);
      push_word(16'($urandom_range(jsu_pkg::LO_SURR_BASE, 16'hDFFF)), 1'b0);
    end else if (r < 93) begin
      // high surrogate joined with an arbitrary word
      push_word(hi, 1'b0);
      push_word(16'($urandom_range(0, 16'hFFFF)), 1'b0);
    end else begin
      push_word(hi, 1'b0);
      push_raw(jsu_pkg::CH_BSLASH, 1'b0);
      push_raw(ESC_CHARS[$urandom_range(0, 7)], 1'b0);
    end
  endfunction

  // the stream ends in one sticky error, followed by bytes that must stay silent
  function automatic void build_random();
    int unsigned n;
    int unsigned junk_at;
    while (stim_q.size() < RANDOM_ITEMS) add_segment();
    push_raw(jsu_pkg::CH_QUOTE, 1'b0);
    junk_at = $urandom_range(0, 3);
    case ($urandom_range(0, 6))
      0: push_raw(8'($urandom_range(0, 255)) & 8'h1F, 1'b1);
      1: push_raw(jsu_pkg::CH_BSLASH, 1'b1);
      2: begin
        push_raw(jsu_pkg::CH_BSLASH, 1'b0);
        push_raw(8'h78, 1'($urandom_range(0, 1)));
      end
      3: begin
        n = $urandom_range(0, 3);
        push_raw(jsu_pkg::CH_BSLASH, 1'b0);
        push_raw(jsu_pkg::CH_U, n == 0);
        for (int i = 1; i <= n; i++) push_raw(digit_or_junk($urandom_range(0, 2) == 0), i == n);
      end
      4: begin
        push_raw(jsu_pkg::CH_BSLASH, 1'b0);
        push_raw(jsu_pkg::CH_U, 1'b0);
        for (int i = 0; i < 4; i++) push_raw(digit_or_junk(i == junk_at), 1'b0);
      end
      5: begin
        push_word(16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX)), 1'b0);
        push_raw(jsu_pkg::CH_BSLASH, 1'b0);
        push_raw(jsu_pkg::CH_U, 1'b0);
        for (int i = 0; i < 4; i++) push_raw(digit_or_junk(i == junk_at), 1'b0);
      end
      default: push_word(16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX)), 1'b1);
    endcase
    repeat (6) push_raw(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    outcome_t e;
    results_seen++;
    if (utf8_pending.size() == 0) begin
      flag_mismatch($sformatf("unexpected transaction kind %0d byte %h code %0d",
                              kind, out_byte, error_code));
    end else begin
      e = utf8_pending.pop_front();
      if (kind !== e.kind || out_byte !== e.data || error_code !== e.code ||
          last_of_run !== e.last)
        flag_mismatch($sformatf("got kind %0d byte %h code %0d last %0b, want %0d %h %0d %0b",
                                kind, out_byte, error_code, last_of_run,
                                e.kind, e.data, e.code, e.last));
      if (e.kind == jsu_pkg::KIND_ERROR) last_err = e.code;
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic fin, row_form_t form, outcome_t typed);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    text_end <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    unescape_byte(b, fin);
    case (form)
      BY_MODEL: foreach (step_out[i]) utf8_pending.insert(utf8_pending.size(), step_out[i]);
      ONE_RESULT: utf8_pending.insert(utf8_pending.size(), typed);
      default: ;
    endcase
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (utf8_pending.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (idle_on && hold_left == 0 && $urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 9);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    row_t     r;
    outcome_t t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      r = DIRECTED[i];
      t.kind = r.k;
      t.data = r.d;
      t.code = r.c;
      t.last = 1'b1;
      send_byte(r.b, r.fin, r.form, t);
    end
    drain_all();
    build_random();
    t = '0;
    foreach (stim_q[k]) begin
      idle_on = !((k >= 150 && k < 200) || k + 60 >= stim_q.size());
      if (k == 250) drain_all();
      send_byte(stim_q[k].b, stim_q[k].fin, BY_MODEL, t);
    end
    drain_all();
    repeat (20) @(posedge clk);
    $display("escapes, \\u words, surrogate pairs and lone surrogates: %0d bytes in, %0d out",
             items_sent, results_seen);
    $display("stream closed by error code %0d, later bytes checked for silence", last_err);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
